@@ rtl/fsbgl_pkg.sv @@
// ----------------------------------------------------------------------------
// fsbgl_pkg
// Shared widths, register indexes, reset values and command type for the
// block group layout unit.
// ----------------------------------------------------------------------------
package fsbgl_pkg;

    localparam int TB_W    = 48;
    localparam int BPG_W   = 20;
    localparam int TI_W    = 32;
    localparam int IPG_W   = 20;
    localparam int GID_W   = 32;
    localparam int CNT_W   = 32;
    localparam int PWR_W   = GID_W + 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TB_W;

    localparam int DIV_STEPS = TB_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_BLK_TOTAL        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_GROUP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_INODES     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INODES_PER_GROUP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARSE_MODE      = 3'd4;

    localparam logic [TB_W-1:0]  RST_BLK_TOTAL        = 48'd1;
    localparam logic [BPG_W-1:0] RST_BLOCKS_PER_GROUP = 20'd8192;
    localparam logic [TI_W-1:0]  RST_TOTAL_INODES     = 32'd0;
    localparam logic [IPG_W-1:0] RST_INODES_PER_GROUP = 20'd2048;

    typedef struct packed {
        logic load;        // capture group id, start divider and power search
        logic step;        // one divider bit and one power step
        logic calc_count;  // form group count from quotient and remainder
        logic calc_prod;   // last group index products and last compare
        logic load_out;    // write the result register
    } fsbgl_cmd_t;

endpackage

@@ rtl/fsbgl_ctrl.sv @@
// ----------------------------------------------------------------------------
// fsbgl_ctrl
// Query sequencer: accepts a beat, runs the divider for DIV_STEPS steps,
// then the count, product and result stages, and owns the result valid.
// ----------------------------------------------------------------------------
module fsbgl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output fsbgl_pkg::fsbgl_cmd_t cmd
);
    import fsbgl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CNT,
        ST_MUL,
        ST_FIN
    } state_t;

    state_t               state_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic                 m_valid_reg;
    logic                 out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd            = '0;
        cmd.load       = (state_reg == ST_IDLE) && s_valid;
        cmd.step       = (state_reg == ST_DIV);
        cmd.calc_count = (state_reg == ST_CNT);
        cmd.calc_prod  = (state_reg == ST_MUL);
        cmd.load_out   = (state_reg == ST_FIN) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_DIV;
                        step_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
                    end
                end
                ST_DIV: begin
                    if (step_reg == '0) begin
                        state_reg <= ST_CNT;
                    end else begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                ST_CNT: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_accept_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DIV))
        else $error("accepted beat did not start the divider");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid_reg)
        else $error("result load did not raise valid");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.load_out)
        else $error("pending result overwritten");

    a_div_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CNT) |-> ($past(state_reg) == ST_DIV && $past(step_reg) == '0))
        else $error("divider ended early");

endmodule

@@ rtl/fsbgl_dp.sv @@
// ----------------------------------------------------------------------------
// fsbgl_dp
// Layout datapath: configuration registers, bit-serial restoring divider,
// power-of-3/5/7 search, last-group products and result register.
// ----------------------------------------------------------------------------
module fsbgl_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fsbgl_pkg::fsbgl_cmd_t               cmd,
    input  logic                                cfg_valid,
    input  logic [fsbgl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fsbgl_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [fsbgl_pkg::GID_W-1:0]         s_group_id,
    output logic [fsbgl_pkg::CNT_W-1:0]         m_group_count,
    output logic [fsbgl_pkg::BPG_W-1:0]         m_blocks_in_group,
    output logic [fsbgl_pkg::TI_W-1:0]          m_inodes_in_group,
    output logic                                m_has_super_copy,
    output logic                                m_is_last_group
);
    import fsbgl_pkg::*;

    logic [TB_W-1:0]  tb_reg;
    logic [BPG_W-1:0] bpg_reg;
    logic [TI_W-1:0]  ti_reg;
    logic [IPG_W-1:0] ipg_reg;
    logic             sparse_reg;

    logic [GID_W-1:0] gid_reg;
    logic [TB_W-1:0]  dvd_reg;
    logic [BPG_W:0]   rem_reg;
    logic [PWR_W-1:0] p3_reg, p5_reg, p7_reg;
    logic [CNT_W-1:0] count_reg;
    logic [BPG_W-1:0] pb_reg;
    logic [TI_W-1:0]  pi_reg;
    logic             is_last_reg;

    logic [CNT_W-1:0] count_out_reg;
    logic [BPG_W-1:0] blocks_reg;
    logic [TI_W-1:0]  inodes_reg;
    logic             super_reg;
    logic             last_out_reg;

    logic [BPG_W:0]   rem_shift;
    logic             fits;
    logic [PWR_W-1:0] gid_ext;
    logic [CNT_W-1:0] last;
    logic             is_pow;
    logic             sparse_hit;

    assign rem_shift  = {rem_reg[BPG_W-1:0], dvd_reg[TB_W-1]};
    assign fits       = rem_shift >= {1'b0, bpg_reg};
    assign gid_ext    = {3'b000, gid_reg};
    assign last       = count_reg - 1'b1;
    assign is_pow     = (p3_reg == gid_ext) || (p5_reg == gid_ext) || (p7_reg == gid_ext);
    assign sparse_hit = (gid_reg[GID_W-1:1] == '0) || (gid_reg[0] && is_pow);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tb_reg     <= RST_BLK_TOTAL;
            bpg_reg    <= RST_BLOCKS_PER_GROUP;
            ti_reg     <= RST_TOTAL_INODES;
            ipg_reg    <= RST_INODES_PER_GROUP;
            sparse_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BLK_TOTAL:        tb_reg     <= cfg_data[TB_W-1:0];
                CFG_BLOCKS_PER_GROUP: bpg_reg    <= cfg_data[BPG_W-1:0];
                CFG_TOTAL_INODES:     ti_reg     <= cfg_data[TI_W-1:0];
                CFG_INODES_PER_GROUP: ipg_reg    <= cfg_data[IPG_W-1:0];
                CFG_SPARSE_MODE:      sparse_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            gid_reg <= s_group_id;
            dvd_reg <= tb_reg;
            rem_reg <= '0;
            p3_reg  <= PWR_W'(3);
            p5_reg  <= PWR_W'(5);
            p7_reg  <= PWR_W'(7);
        end
        if (cmd.step) begin
            rem_reg <= fits ? (rem_shift - {1'b0, bpg_reg}) : rem_shift;
            dvd_reg <= {dvd_reg[TB_W-2:0], fits};
            if (p3_reg < gid_ext) begin
                p3_reg <= PWR_W'(p3_reg * PWR_W'(3));
            end
            if (p5_reg < gid_ext) begin
                p5_reg <= PWR_W'(p5_reg * PWR_W'(5));
            end
            if (p7_reg < gid_ext) begin
                p7_reg <= PWR_W'(p7_reg * PWR_W'(7));
            end
        end
        if (cmd.calc_count) begin
            if (bpg_reg == '0) begin
                count_reg <= '0;
            end else begin
                count_reg <= dvd_reg[CNT_W-1:0] + CNT_W'(rem_reg != '0);
            end
        end
        if (cmd.calc_prod) begin
            pb_reg      <= BPG_W'(last[BPG_W-1:0] * bpg_reg);
            pi_reg      <= TI_W'(last * ipg_reg);
            is_last_reg <= !(gid_reg < last);
        end
        if (cmd.load_out) begin
            count_out_reg <= count_reg;
            last_out_reg  <= is_last_reg;
            super_reg     <= !sparse_reg || sparse_hit;
            if (is_last_reg) begin
                blocks_reg <= tb_reg[BPG_W-1:0] - pb_reg;
                inodes_reg <= ti_reg - pi_reg;
            end else begin
                blocks_reg <= bpg_reg;
                inodes_reg <= TI_W'(ipg_reg);
            end
        end
    end

    assign m_group_count     = count_out_reg;
    assign m_blocks_in_group = blocks_reg;
    assign m_inodes_in_group = inodes_reg;
    assign m_has_super_copy  = super_reg;
    assign m_is_last_group   = last_out_reg;

endmodule

@@ rtl/fs_block_group_layout_unit.sv @@
// ----------------------------------------------------------------------------
// fs_block_group_layout_unit
// Block group layout lookup: group count, blocks and inodes of a group, and
// whether the group carries a superblock copy.
// ----------------------------------------------------------------------------
// One query is in flight at a time: the next beat is taken only once the
// previous result has been loaded into the output register. The group count
// comes from the bit-serial restoring divider, which forms it one quotient
// bit per cycle over all 48 bits of the total block count; the power-of-3/5/7
// search runs alongside it. A finished result sits in the output register
// until taken, while the unit already accepts and works on the next query.
// Configuration writes are always ready and must only be issued while no
// query is pending.
// ----------------------------------------------------------------------------
module fs_block_group_layout_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fsbgl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fsbgl_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fsbgl_pkg::GID_W-1:0]         s_group_id,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fsbgl_pkg::CNT_W-1:0]         m_group_count,
    output logic [fsbgl_pkg::BPG_W-1:0]         m_blocks_in_group,
    output logic [fsbgl_pkg::TI_W-1:0]          m_inodes_in_group,
    output logic                                m_has_super_copy,
    output logic                                m_is_last_group
);
    import fsbgl_pkg::*;

    fsbgl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    fsbgl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    fsbgl_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_group_id        (s_group_id),
        .m_group_count     (m_group_count),
        .m_blocks_in_group (m_blocks_in_group),
        .m_inodes_in_group (m_inodes_in_group),
        .m_has_super_copy  (m_has_super_copy),
        .m_is_last_group   (m_is_last_group)
    );

endmodule
